/* rtl/core/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg: swim stroke detector shared definitions
// Thresholds, register map codes, reset values and axis scaling helper.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int unsigned AXIS_W   = 16;
    localparam int unsigned SCALED_W = 12;
    localparam int unsigned CMP_W    = 13;
    localparam int unsigned TICK_W   = 17;
    localparam int unsigned TOTAL_W  = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 3;

    localparam logic signed [CMP_W-1:0] STEADY_LIMIT  = 13'sd7;
    localparam logic signed [CMP_W-1:0] BEGIN_X_LIMIT = -13'sd30;
    localparam logic signed [CMP_W-1:0] BEGIN_Y_LIMIT = 13'sd30;
    localparam logic signed [CMP_W-1:0] FLICK_X_LIMIT = 13'sd70;
    localparam logic signed [CMP_W-1:0] FLICK_Z_LIMIT = 13'sd60;
    localparam logic signed [CMP_W-1:0] SWEEP_X_LIMIT = -13'sd40;
    localparam logic signed [CMP_W-1:0] SWEEP_Z_LIMIT = -13'sd10;

    localparam logic [TOTAL_W-1:0] STROKE_STEP = 16'd2;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 16'hFFFF;
    localparam logic [TICK_W-1:0]  TICK_MAX    = 17'h1FFFF;

    localparam logic [CFG_W-1:0] MIN_TICKS_RST = 16'd10;
    localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd50;

    typedef enum logic {
        REG_MIN_STROKE_TICKS = 1'b0,
        REG_TIMEOUT_TICKS    = 1'b1
    } t_reg_idx;

    // Divide by 16 toward zero: bias negatives by 15, then drop four bits.
    function automatic logic signed [SCALED_W-1:0] scale_axis(
        input logic signed [AXIS_W-1:0] raw
    );
        logic signed [AXIS_W-1:0] adj;
        adj = raw + $signed({12'd0, {4{raw[AXIS_W-1]}}});
        return adj[AXIS_W-1:4];
    endfunction

endpackage

/* rtl/core/swim_stroke_detector.sv */
// ----------------------------------------------------------------------------
// swim_stroke_detector: arm stroke counter for three-axis accelerometer data
// Scales samples, tracks the begin and end phases of a stroke, counts strokes.
// ----------------------------------------------------------------------------
// Takes one accelerometer sample per clock unless a stalled result holds
// o_ready low, and returns one result per sample: the saturating stroke count
// and the begin and end flags as they stand after that sample. A sample waits
// in the input register and is folded into the stroke state once the result
// register is empty or being taken. The state registers double as the result
// register and hold while the result is stalled. The two threshold registers
// sit at byte addresses 0 and 4; the user must write them only while no sample
// is in flight, as the block itself does not enforce this.
module swim_stroke_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ssd_pkg::AXIS_W-1:0]   i_accel_x,
    input  logic signed [ssd_pkg::AXIS_W-1:0]   i_accel_y,
    input  logic signed [ssd_pkg::AXIS_W-1:0]   i_accel_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ssd_pkg::TOTAL_W-1:0]         o_stroke_count,
    output logic                                o_in_stroke,
    output logic                                o_stroke_ending,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssd_pkg::APB_AW-1:0]          paddr,
    input  logic [ssd_pkg::APB_DW-1:0]          pwdata,
    output logic [ssd_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    logic [ssd_pkg::CFG_W-1:0] r_min_ticks;
    logic [ssd_pkg::CFG_W-1:0] r_timeout;

    logic                              r_in_vld;
    logic signed [ssd_pkg::AXIS_W-1:0] r_ax;
    logic signed [ssd_pkg::AXIS_W-1:0] r_ay;
    logic signed [ssd_pkg::AXIS_W-1:0] r_az;

    logic                                r_out_vld;
    logic signed [ssd_pkg::SCALED_W-1:0] r_prev_x;
    logic                                r_begin;
    logic                                r_end;
    logic [ssd_pkg::TICK_W-1:0]          r_tick;
    logic [ssd_pkg::TOTAL_W-1:0]         r_total;

    logic                                n_begin;
    logic                                n_end;
    logic [ssd_pkg::TICK_W-1:0]          n_tick;
    logic [ssd_pkg::TOTAL_W-1:0]         n_total;

    logic                             w_adv;
    logic                             w_cfg_wr;
    logic signed [ssd_pkg::CMP_W-1:0] w_x;
    logic signed [ssd_pkg::CMP_W-1:0] w_y;
    logic signed [ssd_pkg::CMP_W-1:0] w_z;
    logic signed [ssd_pkg::CMP_W-1:0] w_last;
    logic signed [ssd_pkg::CMP_W-1:0] w_diff;
    logic                             w_begin_hit;
    logic                             w_done;

    assign w_adv    = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready  = !r_in_vld || w_adv;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        case (ssd_pkg::t_reg_idx'(paddr[2]))
            ssd_pkg::REG_MIN_STROKE_TICKS: prdata = {16'd0, r_min_ticks};
            ssd_pkg::REG_TIMEOUT_TICKS:    prdata = {16'd0, r_timeout};
            default:                       prdata = '0;
        endcase
    end

    assign w_x    = ssd_pkg::CMP_W'(ssd_pkg::scale_axis(r_ax));
    assign w_y    = ssd_pkg::CMP_W'(ssd_pkg::scale_axis(r_ay));
    assign w_z    = ssd_pkg::CMP_W'(ssd_pkg::scale_axis(r_az));
    assign w_last = ssd_pkg::CMP_W'(r_prev_x);
    assign w_diff = w_x - w_last;

    assign w_begin_hit = (w_diff < ssd_pkg::STEADY_LIMIT) &&
                         (w_diff > -ssd_pkg::STEADY_LIMIT) &&
                         (w_last < ssd_pkg::BEGIN_X_LIMIT) &&
                         (w_y > ssd_pkg::BEGIN_Y_LIMIT);

    always_comb begin
        n_begin = r_begin || w_begin_hit;
        n_end   = r_end;
        n_tick  = r_tick;
        n_total = r_total;
        w_done  = 1'b0;
        if (n_begin) begin
            if (r_tick != ssd_pkg::TICK_MAX) begin
                n_tick = r_tick + 17'd1;
            end
            if (n_tick >= {1'b0, r_min_ticks}) begin
                if ((w_x > ssd_pkg::FLICK_X_LIMIT) || (w_z > ssd_pkg::FLICK_Z_LIMIT)) begin
                    n_begin = 1'b0;
                    n_end   = 1'b0;
                    n_tick  = '0;
                    w_done  = 1'b1;
                end else if (!r_end && (w_last > w_x) && (w_x < ssd_pkg::SWEEP_X_LIMIT) &&
                             (w_z > ssd_pkg::SWEEP_Z_LIMIT)) begin
                    n_end  = 1'b1;
                    w_done = 1'b1;
                end else if (r_end && !w_x[ssd_pkg::CMP_W-1]) begin
                    if (r_total >= ssd_pkg::TOTAL_MAX - ssd_pkg::STROKE_STEP + 16'd1) begin
                        n_total = ssd_pkg::TOTAL_MAX;
                    end else begin
                        n_total = r_total + ssd_pkg::STROKE_STEP;
                    end
                    n_begin = 1'b0;
                    n_end   = 1'b0;
                    n_tick  = '0;
                    w_done  = 1'b1;
                end
            end
            if (!w_done && (n_tick > {1'b0, r_timeout})) begin
                n_begin = 1'b0;
                n_end   = 1'b0;
                n_tick  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ticks <= ssd_pkg::MIN_TICKS_RST;
            r_timeout   <= ssd_pkg::TIMEOUT_RST;
        end else if (w_cfg_wr) begin
            case (ssd_pkg::t_reg_idx'(paddr[2]))
                ssd_pkg::REG_MIN_STROKE_TICKS: r_min_ticks <= pwdata[ssd_pkg::CFG_W-1:0];
                ssd_pkg::REG_TIMEOUT_TICKS:    r_timeout   <= pwdata[ssd_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_prev_x  <= '0;
            r_begin   <= 1'b0;
            r_end     <= 1'b0;
            r_tick    <= '0;
            r_total   <= '0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_prev_x  <= w_x[ssd_pkg::SCALED_W-1:0];
                r_begin   <= n_begin;
                r_end     <= n_end;
                r_tick    <= n_tick;
                r_total   <= n_total;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_stroke_count  = r_total;
    assign o_in_stroke     = r_begin;
    assign o_stroke_ending = r_end;

`ifndef SYNTHESIS
    a_end_needs_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end |-> r_begin)
        else $error("end flag set outside a stroke");

    a_tick_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_begin |-> (r_tick == '0))
        else $error("tick counter running outside a stroke");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("stroke count decreased");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_total) && $stable(r_begin) && $stable(r_prev_x)))
        else $error("stroke state changed without an item");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for swim_stroke_detector
// Drives accelerometer samples over valid/ready, predicts each result with a
// cycle-free model of the stroke tracker or takes it from a table row, and
// compares field by field. A short table of edge cases comes first, then
// random stroke-shaped sequences mixed with raw noise under several threshold
// settings, then a short run of minimal strokes back to back.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [15:0] count;
        logic        in_stroke;
        logic        ending;
    } t_stroke_result;

    typedef enum logic {
        ROW_SAMPLE = 1'b0,
        ROW_SETUP  = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               typed;
        logic [15:0]        e_count;
        logic               e_in;
        logic               e_end;
    } t_row;

    localparam int SCALE          = 16;
    localparam int STEADY_LIMIT   = 7;
    localparam int BEGIN_X_LIMIT  = -30;
    localparam int BEGIN_Y_LIMIT  = 30;
    localparam int FLICK_X_LIMIT  = 70;
    localparam int FLICK_Z_LIMIT  = 60;
    localparam int SWEEP_X_LIMIT  = -40;
    localparam int SWEEP_Z_LIMIT  = -10;
    localparam int STROKE_STEP    = 2;
    localparam int TOTAL_CAP      = 65535;
    localparam int TICK_CAP       = 131071;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SEG_SAMPLES    = 46;
    localparam int SOAK_STROKES   = 8;
    localparam int SEG_MIN [8]    = '{10, 0, 3, 65535, 0, 65535, 2, 0};
    localparam int SEG_TOUT [8]   = '{50, 0, 12, 65535, 65535, 0, 8, 0};

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_accel_x = '0;
    logic signed [15:0] i_accel_y = '0;
    logic signed [15:0] i_accel_z = '0;
    logic               o_valid;
    logic               i_ready   = 1'b0;
    logic [15:0]        o_stroke_count;
    logic               o_in_stroke;
    logic               o_stroke_ending;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [2:0]         paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    // stroke tracker model state and its copy of the thresholds
    int cfg_min   = 10;
    int cfg_tout  = 50;
    int last_x    = 0;
    bit began     = 1'b0;
    bit ending    = 1'b0;
    int ticks     = 0;
    int total     = 0;

    t_stroke_result expected_results [$];
    t_stroke_result typed_exp_next = '0;
    t_stroke_result pend_exp       = '0;
    logic           typed_next     = 1'b0;
    logic           pend_typed     = 1'b0;

    int tx_idle_pct    = 11;
    int rx_idle_pct    = 50;
    int rx_hold_seq    = 0;
    int rx_hold_taken  = 0;
    int rx_hold_left   = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int cfg_writes     = 0;
    int errors         = 0;

    t_row steps [23] = '{
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd15, 16'sd15, -16'sd17, 1'b1, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd17, -16'sd16, -16'sd1, 1'b1, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd800, 16'sd0, 16'sd0, 1'b1, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd800, 16'sd480, 16'sd0, 1'b1, 16'd0, 1'b0, 1'b0},
        '{ROW_SETUP, 16'sd1, 16'sd3, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd816, 16'sd496, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd15, 16'sd0, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd800, 16'sd0, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd800, 16'sd496, 16'sd976, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd800, 16'sd496, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd800, 16'sd496, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd800, 16'sd0, 16'sh8000, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd800, 16'sd0, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd800, 16'sd496, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, 16'sd1136, 16'sd0, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd800, 16'sd0, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd800, 16'sd496, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd880, 16'sd0, -16'sd160, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd960, 16'sd0, -16'sd159, 1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_SAMPLE, -16'sd16, 16'sd0, 16'sd0, 1'b0, 16'd0, 1'b0, 1'b0}
    };

    swim_stroke_detector u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_accel_z       (i_accel_z),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_stroke_count  (o_stroke_count),
        .o_in_stroke     (o_in_stroke),
        .o_stroke_ending (o_stroke_ending),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic signed [15:0] to_raw(int v);
        int r;
        r = (v == -2048) ? 0 : pick(0, 15);
        if (v < 0 || (v == 0 && pick(0, 1) == 1)) r = -r;
        return 16'(v * SCALE + r);
    endfunction

    function automatic void drop_stroke();
        began  = 1'b0;
        ending = 1'b0;
        ticks  = 0;
    endfunction

    function automatic t_stroke_result advance_tracker(
        logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az
    );
        int x, y, z, prev, diff;
        bit fired;
        t_stroke_result r;
        x = ax;
        y = ay;
        z = az;
        x = x / SCALE;
        y = y / SCALE;
        z = z / SCALE;
        prev = last_x;
        last_x = x;
        diff = (x > prev) ? x - prev : prev - x;
        if (diff < STEADY_LIMIT && prev < BEGIN_X_LIMIT && y > BEGIN_Y_LIMIT) began = 1'b1;
        if (began) begin
            fired = 1'b0;
            if (ticks < TICK_CAP) ticks++;
            if (ticks >= cfg_min) begin
                if (x > FLICK_X_LIMIT || z > FLICK_Z_LIMIT) begin
                    drop_stroke();
                    fired = 1'b1;
                end else if (!ending && prev > x && x < SWEEP_X_LIMIT && z > SWEEP_Z_LIMIT) begin
                    ending = 1'b1;
                    fired  = 1'b1;
                end else if (ending && x >= 0) begin
                    total = (total + STROKE_STEP > TOTAL_CAP) ? TOTAL_CAP : total + STROKE_STEP;
                    drop_stroke();
                    fired = 1'b1;
                end
            end
            if (!fired && ticks > cfg_tout) drop_stroke();
        end
        r.count     = 16'(total);
        r.in_stroke = began;
        r.ending    = ending;
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_stroke_result got, want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            got.count     = o_stroke_count;
            got.in_stroke = o_in_stroke;
            got.ending    = o_stroke_ending;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: expected no result, got count=%0d in=%0b end=%0b", $time,
                         got.count, got.in_stroke, got.ending);
            end else begin
                want = expected_results.pop_front();
                if (got != want) begin
                    errors++;
                    $display("%0t: expected count=%0d in=%0b end=%0b, got count=%0d in=%0b end=%0b",
                             $time, want.count, want.in_stroke, want.ending,
                             got.count, got.in_stroke, got.ending);
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            want = advance_tracker(i_accel_x, i_accel_y, i_accel_z);
            expected_results.push_back(pend_typed ? pend_exp : want);
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            i_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_taken != rx_hold_seq) begin
            i_ready       <= 1'b0;
            rx_hold_taken <= rx_hold_seq;
            rx_hold_left  <= RX_HOLD_CYCLES;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic offer(
        input logic signed [15:0] ax, input logic signed [15:0] ay, input logic signed [15:0] az
    );
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_accel_x  <= ax;
        i_accel_y  <= ay;
        i_accel_z  <= az;
        pend_typed <= typed_next;
        pend_exp   <= typed_exp_next;
        do @(posedge i_clk); while (!o_ready);
        samples_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(
        input logic wr, input ssd_pkg::t_reg_idx idx, input logic [31:0] wdata,
        output logic [31:0] rdata
    );
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_cfg(input ssd_pkg::t_reg_idx idx, input int val);
        logic [31:0] rd;
        apb_xfer(1'b0, idx, '0, rd);
        if (rd != 32'(val)) begin
            errors++;
            $display("%0t: register %s readback expected %0d, got %0d", $time, idx.name(),
                     val, rd);
        end
    endtask

    task automatic write_cfg(input ssd_pkg::t_reg_idx idx, input int val);
        logic [31:0] rd;
        wait_drained();
        apb_xfer(1'b1, idx, 32'(val), rd);
        if (idx == ssd_pkg::REG_MIN_STROKE_TICKS) cfg_min = val;
        else cfg_tout = val;
        cfg_writes++;
        check_cfg(idx, val);
    endtask

    // lead-in, start, hold, return sweep and recovery, with random content
    task automatic swim_stroke();
        int x, k;
        x = -pick(31, 600);
        offer(to_raw(x), to_raw(pick(-300, 300)), to_raw(pick(-9, 40)));
        x = x + ((pick(0, 9) == 0) ? pick(7, 20) : pick(-6, 6));
        offer(to_raw(x), to_raw((pick(0, 9) == 0) ? pick(-40, 30) : pick(31, 900)),
              to_raw(pick(-9, 40)));
        k = pick(0, 14);
        repeat (k) begin
            x = x + pick(-5, 5);
            if (x < -2047) x = -2047;
            case (pick(0, 23))
                0: offer(to_raw(pick(71, 2047)), to_raw(pick(-200, 200)), to_raw(pick(-9, 60)));
                1: offer(to_raw(x), to_raw(pick(-200, 200)), to_raw(pick(61, 2047)));
                default: offer(to_raw(x), to_raw(pick(-200, 200)), to_raw(pick(-9, 60)));
            endcase
        end
        repeat (pick(1, 3)) begin
            x = x - pick(1, 25);
            if (x < -2047) x = -2047;
            offer(to_raw(x), to_raw(pick(-200, 200)),
                  to_raw((pick(0, 5) == 0) ? pick(-60, -10) : pick(-9, 60)));
        end
        offer(to_raw((pick(0, 9) == 0) ? pick(71, 300) : pick(0, 70)), to_raw(pick(-200, 200)),
              to_raw(pick(-60, 60)));
    endtask

    initial begin : stimulus
        int seg_end;
        bit paused;
        paused = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_cfg(ssd_pkg::REG_MIN_STROKE_TICKS, 10);
        check_cfg(ssd_pkg::REG_TIMEOUT_TICKS, 50);

        foreach (steps[i]) begin
            if (steps[i].kind == ROW_SETUP) begin
                write_cfg(ssd_pkg::REG_MIN_STROKE_TICKS, int'(steps[i].x));
                write_cfg(ssd_pkg::REG_TIMEOUT_TICKS, int'(steps[i].y));
            end else begin
                typed_next               = steps[i].typed;
                typed_exp_next.count     = steps[i].e_count;
                typed_exp_next.in_stroke = steps[i].e_in;
                typed_exp_next.ending    = steps[i].e_end;
                offer(steps[i].x, steps[i].y, steps[i].z);
            end
        end
        typed_next = 1'b0;

        for (int seg = 0; seg < 8; seg++) begin
            tx_idle_pct = (seg < 3) ? 11 : ((seg < 6) ? 50 : 0);
            rx_idle_pct = (seg < 3) ? 50 : ((seg < 6) ? 11 : 0);
            write_cfg(ssd_pkg::REG_MIN_STROKE_TICKS, (seg == 7) ? pick(0, 8) : SEG_MIN[seg]);
            write_cfg(ssd_pkg::REG_TIMEOUT_TICKS, (seg == 7) ? pick(0, 60) : SEG_TOUT[seg]);
            // hold the result side off while samples keep coming
            if (seg == 6) rx_hold_seq++;
            seg_end = samples_sent + SEG_SAMPLES;
            while (samples_sent < seg_end) begin
                if (seg == 7 && !paused && samples_sent >= seg_end - SEG_SAMPLES / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if (pick(0, 3) != 0) swim_stroke();
                else repeat (pick(1, 3)) offer(16'($urandom), 16'($urandom), 16'($urandom));
            end
        end

        // run minimal strokes back to back
        write_cfg(ssd_pkg::REG_MIN_STROKE_TICKS, 0);
        write_cfg(ssd_pkg::REG_TIMEOUT_TICKS, 65535);
        repeat (SOAK_STROKES) begin
            offer(-16'sd784, 16'sd0, 16'sd0);
            offer(-16'sd800, 16'sd496, 16'sd0);
            offer(16'sd0, 16'sd0, 16'sd0);
        end
        wait_drained();

        $display("coverage: %0d samples incl. %0d soak, %0d results checked, %0d register writes",
                 samples_sent, 3 * SOAK_STROKES, results_seen, cfg_writes);
        $display("coverage: final stroke count %0d, %0d errors", total, errors);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
